// ===== rtl/core/mmpq_pkg.sv =====
package mmpq_pkg;

    localparam int NUM_QUEUES_DEF    = 16;
    localparam int TABLE_ENTRIES_DEF = 64;

    // field widths
    localparam int CMD_W    = 2;
    localparam int JOB_W    = 31;
    localparam int PRIO_W   = 31;
    localparam int QUEUE_W  = 5;
    localparam int STATUS_W = 3;
    localparam int JOBS_W   = 7;
    localparam int QIU_W    = 5;
    localparam int QIU_RESET = 16;

    // apb
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // digit-serial priority compare
    localparam int DIGIT_W = 4;
    localparam int PAD_W   = 32;
    localparam int NDIG    = PAD_W / DIGIT_W;
    localparam int DIG_CNT_W = $clog2(NDIG);

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_MOVE   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_MOVED    = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADQ     = 3'd5
    } status_t;

    // register map
    localparam logic REG_QUEUES_IN_USE = 1'b0;

endpackage

// ===== rtl/core/mmpq_if.sv =====
interface mmpq_req_if;
    logic                          valid;
    logic                          ready;
    logic [mmpq_pkg::CMD_W-1:0]    command;
    logic [mmpq_pkg::JOB_W-1:0]    job_id;
    logic [mmpq_pkg::PRIO_W-1:0]   priority_req;
    logic [mmpq_pkg::QUEUE_W-1:0]  queue;
    logic [mmpq_pkg::QUEUE_W-1:0]  source_queue;

    modport source (output valid, command, job_id, priority_req, queue, source_queue,
                    input ready);
    modport sink   (input valid, command, job_id, priority_req, queue, source_queue,
                    output ready);
endinterface

interface mmpq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [mmpq_pkg::STATUS_W-1:0] status;
    logic [mmpq_pkg::JOB_W-1:0]    removed_job;
    logic [mmpq_pkg::JOBS_W-1:0]   jobs_waiting;

    modport source (output valid, status, removed_job, jobs_waiting, input ready);
    modport sink   (input valid, status, removed_job, jobs_waiting, output ready);
endinterface

// ===== rtl/core/mergeable_max_priority_queues_top.sv =====
// channel   dir  handshake       payload
// req       in   valid / ready   command, job_id, priority_req, queue, source_queue
// rsp       out  valid / ready   status, removed_job, jobs_waiting
// apb       in   psel / penable  paddr, pwdata -> prdata (queues_in_use at 0x0)
//
// every valid command walks the slot table once, reading then evaluating each slot;
// a remove also compares each further job of the queue with the best so far, over NDIG (8)
// digits, since priorities are compared one 4-bit digit a cycle.
// a bad queue or unknown command skips the walk and answers with ST_BADQ.
// after reset a clearing pass frees every slot; req.ready stays low until it ends.
// a waiting response does not stop the next command from being taken and worked on.
module mergeable_max_priority_queues_top #(
    parameter int NUM_QUEUES    = mmpq_pkg::NUM_QUEUES_DEF,
    parameter int TABLE_ENTRIES = mmpq_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mmpq_req_if.sink                          req,
    mmpq_rsp_if.source                        rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mmpq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mmpq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mmpq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import mmpq_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_CMP   = 7'b0010000,
        S_WRITE = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    // slot table, queue 0 marks a free slot
    logic [QUEUE_W-1:0] q_mem    [TABLE_ENTRIES];
    logic [PRIO_W-1:0]  prio_mem [TABLE_ENTRIES];
    logic [JOB_W-1:0]   job_mem  [TABLE_ENTRIES];

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [DIG_CNT_W-1:0] dig_reg, dig_next;
    logic                 found_reg, found_next;
    logic                 gt_reg, gt_next;
    logic                 decided_reg, decided_next;
    logic                 out_valid_reg, out_valid_next;
    logic [QIU_W-1:0]     qiu_reg;

    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [JOB_W-1:0]     job_reg, job_next;
    logic [PRIO_W-1:0]    prio_reg, prio_next;
    logic [QUEUE_W-1:0]   tq_reg, tq_next;
    logic [QUEUE_W-1:0]   sq_reg, sq_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [JOB_W-1:0]     best_job_reg, best_job_next;
    logic [PAD_W-1:0]     best_sh_reg, best_sh_next;
    logic [PAD_W-1:0]     cand_sh_reg, cand_sh_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    status_t              res_status_reg, res_status_next;
    logic [JOB_W-1:0]     res_job_reg, res_job_next;
    logic [CNT_W-1:0]     res_cnt_reg, res_cnt_next;
    status_t              out_status_reg, out_status_next;
    logic [JOB_W-1:0]     out_job_reg, out_job_next;
    logic [JOBS_W-1:0]    out_jobs_reg, out_jobs_next;

    logic [QUEUE_W-1:0]   rd_q_reg;
    logic [PRIO_W-1:0]    rd_prio_reg;
    logic [JOB_W-1:0]     rd_job_reg;

    logic                 rd_en;
    logic                 q_we;
    logic                 pj_we;
    logic [IDX_W-1:0]     wr_idx;
    logic [QUEUE_W-1:0]   q_wdata;

    logic                 req_fire;
    logic                 rsp_fire;
    logic                 last_slot;
    logic                 hit_t;
    logic                 hit_s;
    logic [DIGIT_W-1:0]   cand_dig;
    logic [DIGIT_W-1:0]   best_dig;
    logic                 gt_now;
    logic [PAD_W-1:0]     cand_rot;
    logic [PAD_W-1:0]     best_rot;

    function automatic logic queue_ok(input logic [QUEUE_W-1:0] q,
                                      input logic [QIU_W-1:0] qiu);
        logic ok;
        ok = (q != '0) && (32'(q) <= 32'(qiu)) && (32'(q) <= NUM_QUEUES);
        return ok;
    endfunction

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign rsp_fire  = rsp.valid && rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.removed_job  = out_job_reg;
    assign rsp.jobs_waiting = out_jobs_reg;

    assign last_slot = (idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign hit_t     = (rd_q_reg == tq_reg);
    assign hit_s     = (rd_q_reg == sq_reg);

    // top digit first, both words rotate so they are whole again after NDIG steps
    assign cand_dig = cand_sh_reg[PAD_W-1 -: DIGIT_W];
    assign best_dig = best_sh_reg[PAD_W-1 -: DIGIT_W];
    assign gt_now   = decided_reg ? gt_reg : (cand_dig > best_dig);
    assign cand_rot = {cand_sh_reg[PAD_W-DIGIT_W-1:0], cand_dig};
    assign best_rot = {best_sh_reg[PAD_W-DIGIT_W-1:0], best_dig};

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        dig_next        = dig_reg;
        found_next      = found_reg;
        gt_next         = gt_reg;
        decided_next    = decided_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        job_next        = job_reg;
        prio_next       = prio_reg;
        tq_next         = tq_reg;
        sq_next         = sq_reg;
        best_idx_next   = best_idx_reg;
        best_job_next   = best_job_reg;
        best_sh_next    = best_sh_reg;
        cand_sh_next    = cand_sh_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_job_next    = res_job_reg;
        res_cnt_next    = res_cnt_reg;
        out_status_next = out_status_reg;
        out_job_next    = out_job_reg;
        out_jobs_next   = out_jobs_reg;
        rd_en           = 1'b0;
        q_we            = 1'b0;
        pj_we           = 1'b0;
        wr_idx          = idx_reg;
        q_wdata         = '0;

        if (rsp_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                q_we    = 1'b1;
                q_wdata = '0;
                if (last_slot)
                begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next   = req.command;
                    job_next   = req.job_id;
                    prio_next  = req.priority_req;
                    tq_next    = req.queue;
                    sq_next    = req.source_queue;
                    idx_next   = '0;
                    found_next = 1'b0;
                    cnt_next   = '0;
                    if ((req.command != CMD_INSERT && req.command != CMD_REMOVE &&
                         req.command != CMD_MOVE) ||
                        !queue_ok(req.queue, qiu_reg) ||
                        (req.command == CMD_MOVE && !queue_ok(req.source_queue, qiu_reg)))
                    begin
                        res_status_next = ST_BADQ;
                        res_job_next    = '0;
                        res_cnt_next    = '0;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                state_next = last_slot ? S_WRITE : S_READ;
                if (!last_slot)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (rd_q_reg == '0 && !found_reg)
                        begin
                            found_next    = 1'b1;
                            best_idx_next = idx_reg;
                        end
                        if (hit_t)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (hit_t)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                            if (!found_reg)
                            begin
                                found_next    = 1'b1;
                                best_idx_next = idx_reg;
                                best_job_next = rd_job_reg;
                                best_sh_next  = PAD_W'(rd_prio_reg);
                            end
                            else
                            begin
                                // hold the slot index while the digits are compared
                                cand_sh_next = PAD_W'(rd_prio_reg);
                                dig_next     = '0;
                                gt_next      = 1'b0;
                                decided_next = 1'b0;
                                idx_next     = idx_reg;
                                state_next   = S_CMP;
                            end
                        end
                    end
                    default:
                    begin
                        if (hit_t || hit_s)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        if (hit_s && !hit_t)
                        begin
                            q_we    = 1'b1;
                            q_wdata = tq_reg;
                        end
                    end
                endcase
            end

            S_CMP:
            begin
                cand_sh_next = cand_rot;
                best_sh_next = best_rot;
                gt_next      = gt_now;
                decided_next = decided_reg || (cand_dig != best_dig);
                dig_next     = dig_reg + 1'b1;
                if (dig_reg == DIG_CNT_W'(NDIG - 1))
                begin
                    // strict greater keeps the lower slot on a tie
                    if (gt_now)
                    begin
                        best_sh_next  = cand_rot;
                        best_idx_next = idx_reg;
                        best_job_next = rd_job_reg;
                    end
                    if (last_slot)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end

            S_WRITE:
            begin
                wr_idx       = best_idx_reg;
                res_job_next = '0;
                state_next   = S_DONE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (found_reg)
                        begin
                            q_we            = 1'b1;
                            pj_we           = 1'b1;
                            q_wdata         = tq_reg;
                            res_status_next = ST_INSERTED;
                            res_cnt_next    = CNT_W'(cnt_reg + 1'b1);
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                            res_cnt_next    = cnt_reg;
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            q_we            = 1'b1;
                            q_wdata         = '0;
                            res_status_next = ST_REMOVED;
                            res_job_next    = best_job_reg;
                            res_cnt_next    = CNT_W'(cnt_reg - 1'b1);
                        end
                        else
                        begin
                            res_status_next = ST_EMPTY;
                            res_cnt_next    = '0;
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_MOVED;
                        res_cnt_next    = cnt_reg;
                    end
                endcase
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_job_next    = res_job_reg;
                    out_jobs_next   = JOBS_W'(res_cnt_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            dig_reg       <= '0;
            found_reg     <= 1'b0;
            gt_reg        <= 1'b0;
            decided_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            dig_reg       <= dig_next;
            found_reg     <= found_next;
            gt_reg        <= gt_next;
            decided_reg   <= decided_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        job_reg        <= job_next;
        prio_reg       <= prio_next;
        tq_reg         <= tq_next;
        sq_reg         <= sq_next;
        best_idx_reg   <= best_idx_next;
        best_job_reg   <= best_job_next;
        best_sh_reg    <= best_sh_next;
        cand_sh_reg    <= cand_sh_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_job_reg    <= res_job_next;
        res_cnt_reg    <= res_cnt_next;
        out_status_reg <= out_status_next;
        out_job_reg    <= out_job_next;
        out_jobs_reg   <= out_jobs_next;
    end

    // slot table ports
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[wr_idx] <= q_wdata;
        end
        if (pj_we)
        begin
            prio_mem[wr_idx] <= prio_reg;
            job_mem[wr_idx]  <= job_reg;
        end
        if (rd_en)
        begin
            rd_q_reg    <= q_mem[idx_reg];
            rd_prio_reg <= prio_mem[idx_reg];
            rd_job_reg  <= job_mem[idx_reg];
        end
    end

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QUEUES_IN_USE) ? APB_DATA_W'(qiu_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qiu_reg <= QIU_W'(QIU_RESET);
        end
        else if (psel && penable && pwrite && paddr[2] == REG_QUEUES_IN_USE)
        begin
            qiu_reg <= pwdata[QIU_W-1:0];
        end
    end

endmodule

// ===== rtl/core/mmpq_checker.sv =====
module mmpq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [mmpq_pkg::STATUS_W-1:0] rsp_status,
    input logic [mmpq_pkg::JOB_W-1:0]    rsp_removed_job,
    input logic [mmpq_pkg::JOBS_W-1:0]   rsp_jobs_waiting
);
    import mmpq_pkg::*;

    // a response waits until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transaction");

    // only a remove carries a job identifier
    a_job_only_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_REMOVED |-> rsp_removed_job == '0)
        else $error("job identifier on non-remove response");

    // rejected or empty answers report no waiting jobs
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_BADQ || rsp_status == ST_EMPTY)
        |-> rsp_jobs_waiting == '0)
        else $error("count on bad queue or empty response");

    // a successful insert leaves at least one job in the queue
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_INSERTED |-> rsp_jobs_waiting != '0)
        else $error("insert reported an empty queue");

endmodule

bind mergeable_max_priority_queues_top mmpq_checker u_mmpq_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_removed_job (rsp.removed_job),
    .rsp_jobs_waiting(rsp.jobs_waiting)
);
